[rtl/upd_pkg.sv]
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared types, character constants and hex helpers for the decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    // Default sizes handed to the top level.
    localparam int LENGTH_BITS_DEF = 16;
    localparam int FIFO_DEPTH_DEF  = 4;
    localparam int LIMIT_W         = 16;
    localparam int OUT_LEN_W       = 16;

    // Reset value of the output limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;

    // Characters the decoder recognizes.
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [3:0] DIGIT_BASE_LETTER = 4'd10;

    typedef logic [7:0] t_byte;

    // Input request payload.
    typedef struct packed {
        t_byte in_byte;
        logic  in_last;
    } t_in;

    // Output request payload.
    typedef struct packed {
        t_byte                out_byte;
        logic                 has_byte;
        logic                 out_last;
        logic [OUT_LEN_W-1:0] out_length;
        logic                 truncated;
    } t_out;

    // One classified input byte: up to three candidate characters.
    typedef struct packed {
        logic [2:0][7:0] chars;
        logic [1:0]      count;
        logic            last;
    } t_entry;

    // Escape sequence progress.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    // True when the character is a hex digit of either case.
    function automatic logic is_hex(t_byte c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
               ((c >= CH_LOW_A) && (c <= CH_LOW_F)) ||
               ((c >= CH_UP_A) && (c <= CH_UP_F));
    endfunction

    // Nibble value of a hex digit character.
    function automatic logic [3:0] hex_nibble(t_byte c);
        logic [3:0] v;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            v = c[3:0];
        end else if ((c >= CH_LOW_A) && (c <= CH_LOW_F)) begin
            v = 4'(c - CH_LOW_A) + DIGIT_BASE_LETTER;
        end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
            v = 4'(c - CH_UP_A) + DIGIT_BASE_LETTER;
        end else begin
            v = 4'd0;
        end
        return v;
    endfunction

endpackage

[rtl/url_percent_decoder.sv]
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder for percent-encoded text with a per-string output limit.
//
// Input requests carry one encoded byte and a flag on the last byte of a
// string; output requests carry one decoded byte (or a bare end marker),
// the running decoded length, the last flag and the truncation flag.
// Both channels use valid/ready. The user must write the limit register
// through i_cfg_we/i_cfg_data only while the block is idle; the block
// itself does not enforce this. A front end classifies each byte in the
// cycle it is accepted and places up to three candidate characters in a
// short queue. The back end emits one output request per cycle while its
// output register is free, so with the queue empty an accepted byte is
// written into the queue and then into the output register before output
// valid rises. Input bytes are accepted one per cycle while the queue has
// room; a byte that breaks an escape expands to up to three outputs, which
// the back end emits one by one while the queue absorbs further input. When
// the receiver stalls, the queue fills and input ready drops. Reset empties
// the queue, clears the escape and counters, and sets the output limit to 256.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
    parameter int LENGTH_BITS = upd_pkg::LENGTH_BITS_DEF,
    parameter int FIFO_DEPTH  = upd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [upd_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  upd_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output upd_pkg::t_out               o_out_data
);

    logic            w_q_full, w_q_push, w_q_pop, w_head_valid;
    upd_pkg::t_entry w_q_data, w_head;

    // Byte classification and escape tracking.
    upd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_data   (i_in_data),
        .o_ready  (o_in_ready),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_data (w_q_data)
    );

    // Queue between classification and emission.
    upd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_q_push),
        .i_push_data  (w_q_data),
        .o_full       (w_q_full),
        .i_pop        (w_q_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // Limit handling and output.
    upd_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_q_pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (o_out_data)
    );

endmodule

[rtl/upd_front.sv]
// ----------------------------------------------------------------------------
// URL percent decoder front end
// Accepts encoded bytes, tracks escape progress and produces the list of
// candidate output characters for each byte.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  upd_pkg::t_in    i_data,
    output logic            o_ready,
    input  logic            i_q_full,
    output logic            o_q_push,
    output upd_pkg::t_entry o_q_data
);

    upd_pkg::t_phase r_phase, n_phase, w_phase_mid;
    upd_pkg::t_byte  r_held, n_held, w_held_mid;
    logic            w_accept;
    logic            w_hex;
    upd_pkg::t_entry w_entry;

    // Append one character to a candidate list.
    function automatic upd_pkg::t_entry add_char(upd_pkg::t_entry e, upd_pkg::t_byte c);
        e.chars[e.count] = c;
        e.count          = e.count + 2'd1;
        return e;
    endfunction

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_hex    = upd_pkg::is_hex(i_data.in_byte);

    // Next escape phase and held digit.
    always_comb begin
        w_phase_mid = r_phase;
        w_held_mid  = r_held;
        case (r_phase)
            upd_pkg::PH_PCT: begin
                if (w_hex) begin
                    w_phase_mid = upd_pkg::PH_DIGIT;
                    w_held_mid  = i_data.in_byte;
                end else if (i_data.in_byte == upd_pkg::CH_PERCENT) begin
                    w_phase_mid = upd_pkg::PH_PCT;
                end else begin
                    w_phase_mid = upd_pkg::PH_IDLE;
                end
            end
            upd_pkg::PH_DIGIT: begin
                if (!w_hex && (i_data.in_byte == upd_pkg::CH_PERCENT)) begin
                    w_phase_mid = upd_pkg::PH_PCT;
                end else begin
                    w_phase_mid = upd_pkg::PH_IDLE;
                end
            end
            default: begin
                if (i_data.in_byte == upd_pkg::CH_PERCENT) begin
                    w_phase_mid = upd_pkg::PH_PCT;
                end else begin
                    w_phase_mid = upd_pkg::PH_IDLE;
                end
            end
        endcase

        n_phase = r_phase;
        n_held  = r_held;
        if (w_accept) begin
            if (i_data.in_last) begin
                n_phase = upd_pkg::PH_IDLE;
                n_held  = '0;
            end else begin
                n_phase = w_phase_mid;
                n_held  = w_held_mid;
            end
        end
    end

    // Candidate characters for the accepted byte.
    always_comb begin
        w_entry      = '0;
        w_entry.last = i_data.in_last;
        case (r_phase)
            upd_pkg::PH_PCT: begin
                if (!w_hex) begin
                    w_entry = add_char(w_entry, upd_pkg::CH_PERCENT);
                    if (i_data.in_byte == upd_pkg::CH_PLUS) begin
                        w_entry = add_char(w_entry, upd_pkg::CH_SPACE);
                    end else if (i_data.in_byte != upd_pkg::CH_PERCENT) begin
                        w_entry = add_char(w_entry, i_data.in_byte);
                    end
                end
            end
            upd_pkg::PH_DIGIT: begin
                if (w_hex) begin
                    w_entry = add_char(w_entry, {upd_pkg::hex_nibble(r_held),
                                                 upd_pkg::hex_nibble(i_data.in_byte)});
                end else begin
                    w_entry = add_char(w_entry, upd_pkg::CH_PERCENT);
                    w_entry = add_char(w_entry, r_held);
                    if (i_data.in_byte == upd_pkg::CH_PLUS) begin
                        w_entry = add_char(w_entry, upd_pkg::CH_SPACE);
                    end else if (i_data.in_byte != upd_pkg::CH_PERCENT) begin
                        w_entry = add_char(w_entry, i_data.in_byte);
                    end
                end
            end
            default: begin
                if (i_data.in_byte == upd_pkg::CH_PLUS) begin
                    w_entry = add_char(w_entry, upd_pkg::CH_SPACE);
                end else if (i_data.in_byte != upd_pkg::CH_PERCENT) begin
                    w_entry = add_char(w_entry, i_data.in_byte);
                end
            end
        endcase

        // A string that ends inside an escape gives the escape back literally.
        if (i_data.in_last) begin
            if (w_phase_mid == upd_pkg::PH_PCT) begin
                w_entry = add_char(w_entry, upd_pkg::CH_PERCENT);
            end else if (w_phase_mid == upd_pkg::PH_DIGIT) begin
                w_entry = add_char(w_entry, upd_pkg::CH_PERCENT);
                w_entry = add_char(w_entry, w_held_mid);
            end
        end
    end

    // Bytes that produce nothing and do not end a string need no queue slot.
    assign o_q_data = w_entry;
    assign o_q_push = w_accept && ((w_entry.count != 2'd0) || w_entry.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upd_pkg::PH_IDLE;
            r_held  <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

[rtl/upd_fifo.sv]
// ----------------------------------------------------------------------------
// URL percent decoder queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module upd_fifo #(
    parameter int DEPTH = upd_pkg::FIFO_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  upd_pkg::t_entry i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output upd_pkg::t_entry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    upd_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full       = (r_cnt == FULL_CNT);
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign w_do_push    = i_push && !o_full;
    assign w_do_pop     = i_pop && o_head_valid;

    // Pointer and fill count updates.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

[rtl/upd_back.sv]
// ----------------------------------------------------------------------------
// URL percent decoder back end
// Emits queued characters one per cycle while the output register is free,
// applies the output limit and tracks the per-string count and truncation flag.
// ----------------------------------------------------------------------------
module upd_back #(
    parameter int LENGTH_BITS = upd_pkg::LENGTH_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [upd_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                        i_head_valid,
    input  upd_pkg::t_entry             i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output upd_pkg::t_out               o_data
);

    // Compare width covers both the limit register and the counter.
    localparam int CW = (LENGTH_BITS > upd_pkg::LIMIT_W) ? LENGTH_BITS : upd_pkg::LIMIT_W;
    localparam logic [CW-1:0] COUNT_MAX = CW'({LENGTH_BITS{1'b1}});

    logic [upd_pkg::LIMIT_W-1:0] r_limit;
    logic [LENGTH_BITS-1:0]      r_count, n_count;
    logic                        r_ovf, n_ovf;
    logic [1:0]                  r_idx, n_idx;
    logic                        r_out_valid, n_out_valid;
    upd_pkg::t_out               r_out, n_out;

    logic [CW-1:0] w_limit_ext, w_cap, w_count_ext, w_inc_ext;
    logic          w_cap_hit, w_next_hit, w_is_last_idx, w_drop_rest, w_out_free;

    assign w_limit_ext   = CW'(r_limit);
    assign w_cap         = (w_limit_ext < COUNT_MAX) ? w_limit_ext : COUNT_MAX;
    assign w_count_ext   = CW'(r_count);
    assign w_inc_ext     = w_count_ext + CW'(1);
    assign w_cap_hit     = (w_count_ext >= w_cap);
    assign w_next_hit    = (w_inc_ext >= w_cap);
    assign w_is_last_idx = (r_idx == (i_head.count - 2'd1));
    assign w_drop_rest   = w_next_hit && !w_is_last_idx;
    assign w_out_free    = !r_out_valid || i_ready;

    // Emit or drop the character at the current index of the head entry.
    always_comb begin
        o_pop       = 1'b0;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        if (i_head_valid) begin
            if ((i_head.count == 2'd0) || w_cap_hit) begin
                // Nothing left to emit: close the string with a bare end marker, or drop a non-final entry.
                if (i_head.last) begin
                    if (w_out_free) begin
                        o_pop              = 1'b1;
                        n_out_valid        = 1'b1;
                        n_out.out_byte     = '0;
                        n_out.has_byte     = 1'b0;
                        n_out.out_last     = 1'b1;
                        n_out.out_length   = w_count_ext[upd_pkg::OUT_LEN_W-1:0];
                        n_out.truncated    = r_ovf || (i_head.count != 2'd0);
                        n_count            = '0;
                        n_ovf              = 1'b0;
                        n_idx              = '0;
                    end
                end else begin
                    o_pop = 1'b1;
                    n_ovf = 1'b1;
                    n_idx = '0;
                end
            end else if (w_out_free) begin
                n_out_valid      = 1'b1;
                n_out.out_byte   = i_head.chars[r_idx];
                n_out.has_byte   = 1'b1;
                n_out.out_length = w_inc_ext[upd_pkg::OUT_LEN_W-1:0];
                n_out.out_last   = 1'b0;
                n_out.truncated  = r_ovf;
                n_count          = LENGTH_BITS'(w_inc_ext);
                if (w_is_last_idx || w_next_hit) begin
                    // Last character of the entry or last that fits; any rest of the entry is dropped.
                    o_pop = 1'b1;
                    n_idx = '0;
                    n_ovf = r_ovf || w_drop_rest;
                    if (i_head.last) begin
                        n_out.out_last  = 1'b1;
                        n_out.truncated = r_ovf || w_drop_rest;
                        n_count         = '0;
                        n_ovf           = 1'b0;
                    end
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= upd_pkg::LIMIT_RESET;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule
